### rtl/ksdp_pkg.sv
// Package for the knapsack profit row update core.
// Holds sequencer state codes, opcodes and stream field positions.
// No dependencies.
package ksdp_pkg;

    typedef logic [2:0] t_state;

    localparam t_state ST_CLEAR = 3'd0;
    localparam t_state ST_IDLE  = 3'd1;
    localparam t_state ST_UPD   = 3'd2;
    localparam t_state ST_DRAIN = 3'd3;
    localparam t_state ST_RD    = 3'd4;
    localparam t_state ST_FIN   = 3'd5;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // input tdata: weight, profit, index from the lowest bit up
    localparam int S_TDATA_W = 48;
    localparam int WEIGHT_W  = 16;
    localparam int PROFIT_W  = 16;
    localparam int INDEX_W   = 10;
    localparam int WEIGHT_LO = 0;
    localparam int PROFIT_LO = 16;
    localparam int INDEX_LO  = 32;

    // input tuser: opcode, first_item from the lowest bit up
    localparam int S_TUSER_W   = 2;
    localparam int TUSER_OP    = 0;
    localparam int TUSER_FIRST = 1;

    localparam int M_TDATA_W = 32;
    localparam int CAP_W     = 10;
    localparam logic [CAP_W-1:0] CAP_RESET = 10'd1023;

    // wide enough for any row index allowed by the design
    localparam int IDX_EXT_W = 17;

endpackage

### rtl/ksdp_row_ram.sv
// Profit row storage: one write port and two registered read ports.
// Generic synchronous memory, no package dependency.
module ksdp_row_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [DATA_W-1:0] o_rdata_a,
    output logic [DATA_W-1:0] o_rdata_b
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rdata_a;
    logic [DATA_W-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= mem[i_raddr_a];
        r_rdata_b <= mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

### rtl/knapsack_dp_row_update_core.sv
// Knapsack profit row update core: top level. Uses ksdp_pkg and ksdp_row_ram.
// Read item: returns the row entry at the index, or zero when the index is past
//   capacity. Add item: with cap = min(capacity, MAX_CAPACITY), the row is swept
//   from entry cap down to 0, one entry per cycle through two read ports. A
//   stalled output delays the result and the next accept of either item kind.
// Reset (synchronous, active low) zeroes all MAX_CAPACITY+1 row entries, no accepts.
module knapsack_dp_row_update_core #(
    parameter int MAX_CAPACITY = 1023,
    parameter int VALUE_BITS   = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ksdp_pkg::CAP_W-1:0]       i_cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // weight [15:0], profit [31:16], index [41:32], zero [47:42]
    input  logic [ksdp_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // opcode [0], first_item [1]
    input  logic [ksdp_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // value [31:0]
    output logic [ksdp_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    localparam int DEPTH  = MAX_CAPACITY + 1;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW     = ksdp_pkg::IDX_EXT_W;
    localparam int SUM_W  = ((VALUE_BITS > ksdp_pkg::PROFIT_W) ? VALUE_BITS
                                                                : ksdp_pkg::PROFIT_W) + 1;
    localparam int SAT_B  = (VALUE_BITS < ksdp_pkg::M_TDATA_W) ? VALUE_BITS
                                                               : ksdp_pkg::M_TDATA_W;
    localparam logic [64:0] SAT_FULL = (65'd1 << SAT_B) - 65'd1;
    localparam logic [SUM_W-1:0] SAT_MAX = SAT_FULL[SUM_W-1:0];
    localparam logic [XW-1:0] MAX_CAP_X = XW'(MAX_CAPACITY);

    ksdp_pkg::t_state r_state;

    logic [ksdp_pkg::CAP_W-1:0]    r_capacity;
    logic [ADDR_W-1:0]             r_j;
    logic                          r_first;
    logic [ksdp_pkg::WEIGHT_W-1:0] r_weight;
    logic [ksdp_pkg::PROFIT_W-1:0] r_profit;
    logic [VALUE_BITS-1:0]         r_res;

    logic                          r_p1_v;
    logic [ADDR_W-1:0]             r_p1_j;
    logic                          r_p1_ge;
    logic                          r_p1_top;

    logic                          r_p2_v;
    logic [ADDR_W-1:0]             r_p2_j;
    logic                          r_p2_ge;
    logic                          r_p2_top;
    logic [VALUE_BITS-1:0]         r_p2_old;
    logic [VALUE_BITS-1:0]         r_p2_cand;

    logic                          r_out_v;
    logic [ksdp_pkg::M_TDATA_W-1:0] r_out_data;

    logic [XW-1:0]         cap_x;
    logic [ADDR_W-1:0]     cap_a;
    logic [XW-1:0]         j_x;
    logic [XW-1:0]         w_x;
    logic [XW-1:0]         diff_x;
    logic                  j_ge_w;
    logic [XW-1:0]         in_idx_x;
    logic                  in_acc;
    logic                  in_op;
    logic                  out_room;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [VALUE_BITS-1:0] ram_wdata;
    logic [ADDR_W-1:0]     ram_raddr_a;
    logic [ADDR_W-1:0]     ram_raddr_b;
    logic [VALUE_BITS-1:0] ram_rdata_a;
    logic [VALUE_BITS-1:0] ram_rdata_b;

    logic [VALUE_BITS-1:0] old_v;
    logic [VALUE_BITS-1:0] base_v;
    logic [SUM_W-1:0]      sum_v;
    logic [SUM_W-1:0]      cand_v;
    logic [VALUE_BITS-1:0] new_v;
    logic [64:0]           res_x;

    // effective capacity: clamp to the row depth
    assign cap_x = (XW'(r_capacity) > MAX_CAP_X) ? MAX_CAP_X : XW'(r_capacity);
    assign cap_a = cap_x[ADDR_W-1:0];

    assign j_x    = XW'(r_j);
    assign w_x    = XW'(r_weight);
    assign diff_x = j_x - w_x;
    assign j_ge_w = (j_x >= w_x);

    assign in_idx_x = XW'(s_axis_tdata[ksdp_pkg::INDEX_LO +: ksdp_pkg::INDEX_W]);
    assign in_op    = s_axis_tuser[ksdp_pkg::TUSER_OP];

    assign s_axis_tready = (r_state == ksdp_pkg::ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_room      = !r_out_v || m_axis_tready;

    // reads: entry j and entry j-weight; writes trail reads through the p1 and p2
    // registers at higher indices, so a descending sweep never reads a fresh entry
    assign ram_raddr_a = (r_state == ksdp_pkg::ST_IDLE) ? in_idx_x[ADDR_W-1:0] : r_j;
    assign ram_raddr_b = diff_x[ADDR_W-1:0];

    assign old_v  = r_first ? '0 : ram_rdata_a;
    assign base_v = r_first ? '0 : ram_rdata_b;
    assign sum_v  = SUM_W'(base_v) + SUM_W'(r_profit);
    assign cand_v = (sum_v >= SAT_MAX) ? SAT_MAX : sum_v;

    assign new_v = (r_p2_ge && (r_p2_cand > r_p2_old)) ? r_p2_cand : r_p2_old;

    assign ram_we    = (r_state == ksdp_pkg::ST_CLEAR) || r_p2_v;
    assign ram_waddr = (r_state == ksdp_pkg::ST_CLEAR) ? r_j : r_p2_j;
    assign ram_wdata = (r_state == ksdp_pkg::ST_CLEAR) ? '0 : new_v;

    ksdp_row_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (VALUE_BITS)
    ) u_row_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_a (ram_rdata_a),
        .o_rdata_b (ram_rdata_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= ksdp_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    // read/modify pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
        end else begin
            r_p1_v <= (r_state == ksdp_pkg::ST_UPD);
            r_p2_v <= r_p1_v;
        end
        r_p1_j    <= r_j;
        r_p1_ge   <= j_ge_w;
        r_p1_top  <= (r_j == cap_a);
        r_p2_j    <= r_p1_j;
        r_p2_ge   <= r_p1_ge;
        r_p2_top  <= r_p1_top;
        r_p2_old  <= old_v;
        r_p2_cand <= cand_v[VALUE_BITS-1:0];
    end

    assign res_x = 65'(r_res);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ksdp_pkg::ST_CLEAR;
            r_j     <= '0;
            r_out_v <= 1'b0;
        end else begin
            // drop the taken item unless a new one loads in the same cycle
            if (r_out_v && m_axis_tready && (r_state != ksdp_pkg::ST_FIN)) begin
                r_out_v <= 1'b0;
            end
            if (r_p2_v && r_p2_top) begin
                r_res <= new_v;
            end
            unique case (r_state)
                ksdp_pkg::ST_CLEAR: begin
                    if (XW'(r_j) == MAX_CAP_X) begin
                        r_state <= ksdp_pkg::ST_IDLE;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                ksdp_pkg::ST_IDLE: begin
                    if (in_acc) begin
                        r_first  <= s_axis_tuser[ksdp_pkg::TUSER_FIRST];
                        r_weight <= s_axis_tdata[ksdp_pkg::WEIGHT_LO +: ksdp_pkg::WEIGHT_W];
                        r_profit <= s_axis_tdata[ksdp_pkg::PROFIT_LO +: ksdp_pkg::PROFIT_W];
                        r_j      <= cap_a;
                        if (in_op == ksdp_pkg::OP_ADD) begin
                            r_state <= ksdp_pkg::ST_UPD;
                        end else if (in_idx_x > cap_x) begin
                            r_res   <= '0;
                            r_state <= ksdp_pkg::ST_FIN;
                        end else begin
                            r_state <= ksdp_pkg::ST_RD;
                        end
                    end
                end
                ksdp_pkg::ST_UPD: begin
                    if (r_j == '0) begin
                        r_state <= ksdp_pkg::ST_DRAIN;
                    end else begin
                        r_j <= r_j - 1'b1;
                    end
                end
                ksdp_pkg::ST_DRAIN: begin
                    if (!r_p1_v && !r_p2_v) begin
                        r_state <= ksdp_pkg::ST_FIN;
                    end
                end
                ksdp_pkg::ST_RD: begin
                    r_res   <= ram_rdata_a;
                    r_state <= ksdp_pkg::ST_FIN;
                end
                ksdp_pkg::ST_FIN: begin
                    // hold the result until the output register frees up
                    if (out_room) begin
                        r_out_v    <= 1'b1;
                        r_out_data <= res_x[ksdp_pkg::M_TDATA_W-1:0];
                        r_state    <= ksdp_pkg::ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ksdp_pkg::ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_data;

    a_write_above_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p2_v && (r_state == ksdp_pkg::ST_UPD)) |-> (r_p2_j > r_j))
        else $error("row write overlaps a pending read");

    a_write_in_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p2_v |-> (XW'(r_p2_j) <= cap_x))
        else $error("row write beyond capacity");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ksdp_pkg::ST_CLEAR) |-> (!r_p1_v && !r_p2_v && !r_out_v))
        else $error("activity during clearing pass");

    a_fin_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ksdp_pkg::ST_FIN) |-> (!r_p1_v && !r_p2_v))
        else $error("result taken before row update drained");

endmodule
